### rtl/shifted_patterned_minimizer_sketch_core_defines.svh
`ifndef SHIFTED_PATTERNED_MINIMIZER_SKETCH_CORE_DEFINES_SVH
`define SHIFTED_PATTERNED_MINIMIZER_SKETCH_CORE_DEFINES_SVH

// Check that must hold in the same cycle.
`define SPMS_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check on the cycle after the trigger.
`define SPMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/spms_pkg.sv
`default_nettype none

package spms_pkg;

  localparam int WINDOW_DEPTH_DEF = 32;
  localparam int PATTERN_MAX_DEF  = 40;
  localparam int KMER_MAX_DEF     = 28;

  localparam int HASH_W     = 56;
  localparam int KEY_W      = 64;
  localparam int LOC_W      = 32;
  localparam int MASK_W     = 40;
  localparam int CFG_W      = 40;
  localparam int CFG_ADDR_W = 3;
  localparam int HASH_STEPS = 7;
  localparam int COUNT_W    = 32;
  localparam int RES_MAX    = 64;

  localparam logic [KEY_W-1:0] KEY_EMPTY = '1;
  localparam logic [LOC_W-1:0] LOC_EMPTY = '1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WINDOW_SIZE,
    REG_KMER_LEN,
    REG_REF_ID,
    REG_PATTERN_MASK,
    REG_PATTERN_LEN,
    REG_START_SHIFT
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] base_char;
    logic       last;
  } base_beat_t;

  typedef struct packed {
    logic [55:0] hash_key;
    logic [4:0]  span;
    logic [30:0] position;
    logic        strand;
    logic [31:0] seq_id;
    logic        final_of_run;
  } sketch_beat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_STEP,
    S_SAMPLE,
    S_HASH,
    S_POP,
    S_MOD,
    S_NTH,
    S_POS,
    S_WRITE,
    S_TIES1,
    S_DECIDE,
    S_RESCAN,
    S_RESCAN_CHK,
    S_TIES2,
    S_SLOT,
    S_LAST,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic accept;
    logic do_step;
    logic do_sample;
    logic hash_step;
    logic pop_step;
    logic mod_step;
    logic nth_step;
    logic step_clr;
    logic pos_commit;
    logic win_write;
    logic t_init;
    logic t_inc;
    logic set_min_new;
    logic clear_min;
    logic rescan_step;
    logic emit_min;
    logic emit_tie;
    logic slot_advance;
    logic clear_all;
    logic push_final;
  } dp_cmd_t;

  typedef struct packed {
    logic skipping;
    logic pat_hit;
    logic code_ok;
    logic sym;
    logic hashable;
    logic hash_last;
    logic pop_last;
    logic mod_last;
    logic nth_last;
    logic tie1;
    logic cond_a;
    logic cond_b;
    logic key_le;
    logic bp_is_min;
    logic lt_w;
    logic le_w;
    logic tie_hit;
    logic min_empty;
    logic push_ok;
    logic res_full;
    logic pend_valid;
    logic out_free;
    logic last;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/spms_ctrl.sv
`default_nettype none

module spms_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 base_valid,
  output logic                 base_stall,
  input  spms_pkg::dp_status_t st,
  output spms_pkg::dp_cmd_t    cmd
);
  import spms_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign base_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (base_valid) begin
          cmd.accept = 1'b1;
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        cmd.do_step = 1'b1;
        state_next  = (!st.skipping && st.pat_hit) ? S_SAMPLE : S_LAST;
      end
      S_SAMPLE: begin
        cmd.do_sample = 1'b1;
        cmd.step_clr  = 1'b1;
        if (!st.code_ok) begin
          state_next = S_WRITE;
        end else if (st.sym) begin
          state_next = S_LAST;
        end else if (st.hashable) begin
          state_next = S_HASH;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (st.hash_last) begin
          cmd.step_clr = 1'b1;
          state_next   = S_POP;
        end
      end
      S_POP: begin
        cmd.pop_step = 1'b1;
        if (st.pop_last) begin
          cmd.step_clr = 1'b1;
          state_next   = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (st.mod_last) begin
          cmd.step_clr = 1'b1;
          state_next   = S_NTH;
        end
      end
      S_NTH: begin
        cmd.nth_step = 1'b1;
        if (st.nth_last) begin
          cmd.step_clr = 1'b1;
          state_next   = S_POS;
        end
      end
      S_POS: begin
        cmd.pos_commit = 1'b1;
        state_next     = S_WRITE;
      end
      S_WRITE: begin
        cmd.win_write = 1'b1;
        cmd.t_init    = 1'b1;
        state_next    = st.tie1 ? S_TIES1 : S_DECIDE;
      end
      S_TIES1: begin
        if (!st.lt_w) begin
          state_next = S_DECIDE;
        end else if (!(st.tie_hit && !st.res_full && !st.push_ok)) begin
          cmd.emit_tie = st.tie_hit;
          cmd.t_inc    = 1'b1;
        end
      end
      S_DECIDE: begin
        if (st.key_le) begin
          if (!(st.cond_a && !st.res_full && !st.push_ok)) begin
            cmd.emit_min    = st.cond_a;
            cmd.set_min_new = 1'b1;
            state_next      = S_SLOT;
          end
        end else if (st.bp_is_min) begin
          if (!(st.cond_b && !st.res_full && !st.push_ok)) begin
            cmd.emit_min  = st.cond_b;
            cmd.clear_min = 1'b1;
            cmd.t_init    = 1'b1;
            state_next    = S_RESCAN;
          end
        end else begin
          state_next = S_SLOT;
        end
      end
      S_RESCAN: begin
        if (st.le_w) begin
          cmd.rescan_step = 1'b1;
          cmd.t_inc       = 1'b1;
        end else begin
          state_next = S_RESCAN_CHK;
        end
      end
      S_RESCAN_CHK: begin
        cmd.t_init = 1'b1;
        state_next = st.cond_b ? S_TIES2 : S_SLOT;
      end
      S_TIES2: begin
        if (!st.le_w) begin
          state_next = S_SLOT;
        end else if (!(st.tie_hit && !st.res_full && !st.push_ok)) begin
          cmd.emit_tie = st.tie_hit;
          cmd.t_inc    = 1'b1;
        end
      end
      S_SLOT: begin
        cmd.slot_advance = 1'b1;
        state_next       = S_LAST;
      end
      S_LAST: begin
        if (!st.last) begin
          state_next = S_FLUSH;
        end else if (!(!st.min_empty && !st.res_full && !st.push_ok)) begin
          cmd.emit_min  = !st.min_empty;
          cmd.clear_all = 1'b1;
          state_next    = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!st.pend_valid) begin
          state_next = S_IDLE;
        end else if (st.out_free) begin
          cmd.push_final = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/spms_dp.sv
`default_nettype none

`include "shifted_patterned_minimizer_sketch_core_defines.svh"

module spms_dp #(
  parameter int WINDOW_DEPTH = spms_pkg::WINDOW_DEPTH_DEF,
  parameter int PATTERN_MAX  = spms_pkg::PATTERN_MAX_DEF,
  parameter int KMER_MAX     = spms_pkg::KMER_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  spms_pkg::base_beat_t                base_beat,
  output logic                                sketch_valid,
  input  logic                                sketch_stall,
  output spms_pkg::sketch_beat_t              sketch_beat,
  input  logic                                cfg_we,
  input  logic [spms_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [spms_pkg::CFG_W-1:0]          cfg_data,
  input  spms_pkg::dp_cmd_t                   cmd,
  output spms_pkg::dp_status_t                st
);
  import spms_pkg::*;

  localparam int SW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int WW   = $clog2(WINDOW_DEPTH + 1);
  localparam int TW   = WW + 1;
  localparam int SUMW = (WW + 2 > 7) ? WW + 2 : 7;
  localparam int KW   = 2 * KMER_MAX;
  localparam logic [2:0] BASE_AMBIG = 3'd4;

  // configuration
  logic [5:0]        ws;
  logic [4:0]        kl;
  logic [31:0]       ref_id;
  logic [MASK_W-1:0] pmask;
  logic [5:0]        plen_r;
  logic [11:0]       shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      ws     <= 6'd10;
      kl     <= 5'd15;
      ref_id <= '0;
      pmask  <= '1;
      plen_r <= 6'd1;
      shift  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_WINDOW_SIZE:  ws     <= cfg_data[5:0];
        REG_KMER_LEN:     kl     <= cfg_data[4:0];
        REG_REF_ID:       ref_id <= cfg_data[31:0];
        REG_PATTERN_MASK: pmask  <= cfg_data[MASK_W-1:0];
        REG_PATTERN_LEN:  plen_r <= cfg_data[5:0];
        REG_START_SHIFT:  shift  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  logic [WW-1:0] w_eff;
  logic [4:0]    k_eff;
  logic [5:0]    plen;
  logic [KW-1:0] kmask;

  always_comb begin
    if (ws == '0) begin
      w_eff = WW'(1);
    end else if (int'(ws) > WINDOW_DEPTH) begin
      w_eff = WW'(WINDOW_DEPTH);
    end else begin
      w_eff = WW'(ws);
    end
    if (kl == '0) begin
      k_eff = 5'd1;
    end else if (int'(kl) > KMER_MAX) begin
      k_eff = 5'(KMER_MAX);
    end else begin
      k_eff = kl;
    end
    if (plen_r == '0) begin
      plen = 6'd1;
    end else if (int'(plen_r) > PATTERN_MAX) begin
      plen = 6'(PATTERN_MAX);
    end else begin
      plen = plen_r;
    end
    kmask = {KW{1'b1}} >> (7'(KW) - {1'b0, k_eff, 1'b0});
  end

  function automatic logic pbit(logic [5:0] g, logic [5:0] pl, logic [MASK_W-1:0] pm);
    logic r;
    r = 1'b0;
    if (g < pl && int'(g) < MASK_W) begin
      r = pm[g];
    end
    return r;
  endfunction

  function automatic logic [2:0] base_code(logic [7:0] b);
    logic [2:0] r;
    unique case (b)
      8'd0, 8'd1, 8'd2, 8'd3: r = {1'b0, b[1:0]};
      8'h41, 8'h61:           r = 3'd0;
      8'h43, 8'h63:           r = 3'd1;
      8'h47, 8'h67:           r = 3'd2;
      8'h54, 8'h74, 8'h55, 8'h75: r = 3'd3;
      default:                r = BASE_AMBIG;
    endcase
    return r;
  endfunction

  function automatic logic [KW-1:0] hash_step(logic [KW-1:0] x, logic [KW-1:0] m,
                                              logic [2:0] s);
    logic [KW-1:0] r;
    case (s)
      3'd0:    r = (~x + (x << 21)) & m;
      3'd1:    r = x ^ (x >> 24);
      3'd2:    r = (x + (x << 3) + (x << 8)) & m;
      3'd3:    r = x ^ (x >> 14);
      3'd4:    r = (x + (x << 2) + (x << 4)) & m;
      3'd5:    r = x ^ (x >> 28);
      default: r = (x + (x << 31)) & m;
    endcase
    return r;
  endfunction

  // sketch state
  logic [KEY_W-1:0]  win_key [WINDOW_DEPTH];
  logic [LOC_W-1:0]  win_loc [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] win_vld;
  logic [KEY_W-1:0]  min_key;
  logic [LOC_W-1:0]  min_loc;
  logic [SW-1:0]     min_slot;
  logic [SW-1:0]     wslot;
  logic [KW-1:0]     fwd;
  logic [KW-1:0]     rev;
  logic [5:0]        run;
  logic [COUNT_W-1:0] ecount;
  logic [30:0]       poff;
  logic [5:0]        phase;
  logic [11:0]       skip;

  // per-beat work registers
  logic [7:0]        base_c;
  logic              last_r;
  logic              z;
  logic [4:0]        span;
  logic [KW-1:0]     x;
  logic [5:0]        ones;
  logic [5:0]        rem;
  logic [5:0]        nth_n;
  logic [5:0]        nth_g;
  logic              nth_found;
  logic              r_zero;
  logic [KEY_W-1:0]  cur_key;
  logic [LOC_W-1:0]  cur_loc;
  logic [SW-1:0]     bp;
  logic [5:0]        step;
  logic [TW-1:0]     t;
  logic [6:0]        res_n;
  logic              pend_valid;
  logic [KEY_W-1:0]  pend_key;
  logic [LOC_W-1:0]  pend_loc;

  // combinational helpers
  logic [2:0]        code;
  logic [KW-1:0]     fwd_new;
  logic [KW-1:0]     rev_new;
  logic [5:0]        run_inc;
  logic [4:0]        span_new;
  logic [5:0]        g_eff;
  logic [5:0]        ones_eff;
  logic [6:0]        rsh;
  logic [5:0]        rem_new;
  logic [TW:0]       jsum;
  logic [SW-1:0]     j;
  logic [KEY_W-1:0]  rk;
  logic [LOC_W-1:0]  rl;
  logic [SW-1:0]     bp_c;
  logic [SUMW-1:0]   wk;
  logic [SUMW-1:0]   run_x;
  logic              min_empty;
  logic              out_free;
  logic              push_ok;
  logic              res_full;
  logic              emit_vld;
  logic [KEY_W-1:0]  emit_key;
  logic [LOC_W-1:0]  emit_loc;
  logic              push_any;

  always_comb begin
    code     = base_code(base_c);
    fwd_new  = ((fwd << 2) | KW'(code[1:0])) & kmask;
    rev_new  = (rev >> 2) | (KW'(2'b11 ^ code[1:0]) << {k_eff - 5'd1, 1'b0});
    run_inc  = (run == 6'd63) ? run : run + 6'd1;
    span_new = ((7'(run) + 7'd1) < 7'(k_eff)) ? 5'(run + 6'd1) : k_eff;
    g_eff    = (phase >= plen) ? '0 : phase;
    ones_eff = (ones == '0) ? 6'd1 : ones;
    rsh      = {rem, ecount[5'(COUNT_W - 1) - step[4:0]]};
    rem_new  = (rsh >= {1'b0, ones_eff}) ? 6'(rsh - {1'b0, ones_eff}) : rsh[5:0];
    jsum     = (TW+1)'(bp) + (TW+1)'(t);
    if (jsum >= (TW+1)'(w_eff)) begin
      jsum = jsum - (TW+1)'(w_eff);
    end
    j        = jsum[SW-1:0];
    rk       = win_vld[j] ? win_key[j] : KEY_EMPTY;
    rl       = win_vld[j] ? win_loc[j] : LOC_EMPTY;
    bp_c     = (int'(wslot) >= int'(w_eff)) ? '0 : wslot;
    wk       = SUMW'(w_eff) + SUMW'(k_eff);
    run_x    = SUMW'(run);
    min_empty = (min_key == KEY_EMPTY);
    out_free = !sketch_valid || !sketch_stall;
    push_ok  = !pend_valid || out_free;
    res_full = (res_n >= 7'(RES_MAX));
    emit_vld = (cmd.emit_min || cmd.emit_tie) && !res_full;
    emit_key = cmd.emit_min ? min_key : rk;
    emit_loc = cmd.emit_min ? min_loc : rl;
    push_any = (emit_vld && pend_valid) || cmd.push_final;
  end

  always_comb begin
    st            = '0;
    st.skipping   = (skip < shift);
    st.pat_hit    = pbit(g_eff, plen, pmask);
    st.code_ok    = (code != BASE_AMBIG);
    st.sym        = (fwd_new == rev_new);
    st.hashable   = (run_inc >= 6'(k_eff));
    st.hash_last  = (step == 6'(HASH_STEPS - 1));
    st.pop_last   = (step == plen - 6'd1);
    st.mod_last   = (step == 6'(COUNT_W - 1));
    st.nth_last   = (step == plen - 6'd1);
    st.tie1       = (run_x == wk - SUMW'(1)) && !min_empty;
    st.cond_a     = (run_x >= wk) && !min_empty;
    st.cond_b     = (run_x >= wk - SUMW'(1)) && !min_empty;
    st.key_le     = (cur_key <= min_key);
    st.bp_is_min  = (bp == min_slot);
    st.lt_w       = (t < TW'(w_eff));
    st.le_w       = (t <= TW'(w_eff));
    st.tie_hit    = (rk == min_key) && (rl != min_loc);
    st.min_empty  = min_empty;
    st.push_ok    = push_ok;
    st.res_full   = res_full;
    st.pend_valid = pend_valid;
    st.out_free   = out_free;
    st.last       = last_r;
  end

  // sketch state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      win_vld  <= '0;
      min_key  <= KEY_EMPTY;
      min_loc  <= LOC_EMPTY;
      min_slot <= '0;
      wslot    <= '0;
      fwd      <= '0;
      rev      <= '0;
      run      <= '0;
      ecount   <= COUNT_W'(1);
      poff     <= '0;
      phase    <= '0;
      skip     <= '0;
    end else begin
      if (cmd.do_step) begin
        if (skip < shift) begin
          skip <= skip + 12'd1;
        end else begin
          phase <= (g_eff + 6'd1 >= plen) ? '0 : g_eff + 6'd1;
        end
      end
      if (cmd.do_sample) begin
        if (code != BASE_AMBIG) begin
          fwd <= fwd_new;
          rev <= rev_new;
          if (fwd_new != rev_new) begin
            run <= run_inc;
          end
        end else begin
          run <= '0;
        end
      end
      if (cmd.pos_commit) begin
        ecount <= ecount + COUNT_W'(1);
        if (r_zero) begin
          poff <= poff + 31'(plen);
        end
      end
      if (cmd.win_write) begin
        win_vld[bp_c] <= 1'b1;
      end
      if (cmd.set_min_new) begin
        min_key  <= cur_key;
        min_loc  <= cur_loc;
        min_slot <= bp;
      end else if (cmd.clear_min) begin
        min_key <= KEY_EMPTY;
      end else if (cmd.rescan_step && (min_key >= rk)) begin
        min_key  <= rk;
        min_loc  <= rl;
        min_slot <= j;
      end
      if (cmd.slot_advance) begin
        wslot <= (int'(bp) + 1 >= int'(w_eff)) ? '0 : SW'(int'(bp) + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win_write) begin
      win_key[bp_c] <= cur_key;
      win_loc[bp_c] <= cur_loc;
    end
  end

  // per-beat datapath
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      base_c <= base_beat.base_char;
      last_r <= base_beat.last;
    end
    if (cmd.do_sample) begin
      cur_key   <= KEY_EMPTY;
      cur_loc   <= LOC_EMPTY;
      z         <= !(fwd_new < rev_new);
      span      <= span_new;
      x         <= (fwd_new < rev_new) ? fwd_new : rev_new;
      ones      <= '0;
      rem       <= '0;
      nth_found <= 1'b0;
      nth_g     <= '0;
    end
    if (cmd.hash_step) begin
      x <= hash_step(x, kmask, step[2:0]);
    end
    if (cmd.pop_step) begin
      ones <= ones + 6'(pbit(step, plen, pmask));
    end
    if (cmd.mod_step) begin
      rem <= rem_new;
      if (step == 6'(COUNT_W - 1)) begin
        r_zero <= (rem_new == '0);
        nth_n  <= (rem_new == '0) ? ones_eff - 6'd1 : rem_new - 6'd1;
      end
    end
    if (cmd.nth_step && !nth_found && pbit(step, plen, pmask)) begin
      if (nth_n == '0) begin
        nth_found <= 1'b1;
        nth_g     <= step;
      end else begin
        nth_n <= nth_n - 6'd1;
      end
    end
    if (cmd.pos_commit) begin
      cur_key <= {HASH_W'(x), 3'b000, span};
      cur_loc <= {poff + 31'(nth_g), z};
    end
    if (cmd.win_write) begin
      bp <= bp_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      t    <= '0;
    end else begin
      if (cmd.step_clr) begin
        step <= '0;
      end else if (cmd.hash_step || cmd.pop_step || cmd.mod_step || cmd.nth_step) begin
        step <= step + 6'd1;
      end
      if (cmd.t_init) begin
        t <= TW'(1);
      end else if (cmd.t_inc) begin
        t <= t + TW'(1);
      end
    end
  end

  // result hold and output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid   <= 1'b0;
      sketch_valid <= 1'b0;
      res_n        <= '0;
    end else begin
      if (cmd.accept) begin
        res_n <= '0;
      end else if (emit_vld) begin
        res_n <= res_n + 7'd1;
      end
      if (emit_vld) begin
        pend_valid <= 1'b1;
      end else if (cmd.push_final) begin
        pend_valid <= 1'b0;
      end
      if (push_any) begin
        sketch_valid <= 1'b1;
      end else if (sketch_valid && !sketch_stall) begin
        sketch_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_vld) begin
      pend_key <= emit_key;
      pend_loc <= emit_loc;
    end
    if (push_any) begin
      sketch_beat.hash_key     <= pend_key[KEY_W-1:8];
      sketch_beat.span         <= pend_key[4:0];
      sketch_beat.position     <= pend_loc[LOC_W-1:1];
      sketch_beat.strand       <= pend_loc[0];
      sketch_beat.seq_id       <= ref_id;
      sketch_beat.final_of_run <= cmd.push_final;
    end
  end

  `SPMS_ASSERT_HOLDS(a_push_needs_room, !push_any || out_free,
    "result pushed into a busy output register")
  `SPMS_ASSERT_HOLDS(a_result_cap, res_n <= 7'(RES_MAX),
    "result count past its cap")
  `SPMS_ASSERT_NEXT(a_slot_in_window, cmd.win_write, int'(bp) < int'(w_eff),
    "window slot outside the window")
  `SPMS_ASSERT_NEXT(a_clear_empties, cmd.clear_all, min_empty && (win_vld == '0),
    "state clear left the window occupied")

endmodule

`default_nettype wire

### rtl/shifted_patterned_minimizer_sketch_core.sv
// Per base, accept to next accept: a base that is skipped or masked out takes the shortest
// path, a symmetric k-mer is also sampled, and a sampled base that is not hashed is also written
// to the window; hashing adds 7 hash steps, a plen-step pattern count, a 32-step count modulo
// and a plen-step pattern search. Tie passes and a window rescan may follow; an output stall holds each result.
// Throughput: one base in flight; the next base is taken once the previous one is done,
// while its last result may still wait in the output register. Reset: rst synchronous.
`default_nettype none

module shifted_patterned_minimizer_sketch_core #(
  parameter int WINDOW_DEPTH = spms_pkg::WINDOW_DEPTH_DEF,
  parameter int PATTERN_MAX  = spms_pkg::PATTERN_MAX_DEF,
  parameter int KMER_MAX     = spms_pkg::KMER_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            base_valid,
  output logic                            base_stall,
  input  spms_pkg::base_beat_t            base_beat,
  output logic                            sketch_valid,
  input  logic                            sketch_stall,
  output spms_pkg::sketch_beat_t          sketch_beat,
  input  logic                            cfg_we,
  input  logic [spms_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [spms_pkg::CFG_W-1:0]      cfg_data
);
  import spms_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  spms_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .base_valid (base_valid),
    .base_stall (base_stall),
    .st         (st),
    .cmd        (cmd)
  );

  spms_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .PATTERN_MAX  (PATTERN_MAX),
    .KMER_MAX     (KMER_MAX)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .base_beat    (base_beat),
    .sketch_valid (sketch_valid),
    .sketch_stall (sketch_stall),
    .sketch_beat  (sketch_beat),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .st           (st)
  );

endmodule

`default_nettype wire

### sim/tb.sv
module tb;
  import spms_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  base_valid;
  logic                  base_stall;
  base_beat_t            base_beat;
  logic                  sketch_valid;
  logic                  sketch_stall;
  sketch_beat_t          sketch_beat;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_W-1:0]      cfg_data;

  shifted_patterned_minimizer_sketch_core u_top (
    .clk(clk), .rst(rst),
    .base_valid(base_valid), .base_stall(base_stall), .base_beat(base_beat),
    .sketch_valid(sketch_valid), .sketch_stall(sketch_stall), .sketch_beat(sketch_beat),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // shadow registers
  bit [5:0]  sh_win;
  bit [4:0]  sh_k;
  bit [31:0] sh_id;
  bit [39:0] sh_mask;
  bit [5:0]  sh_plen;
  bit [11:0] sh_shift;

  // sketch state
  bit [63:0]   win_key [WINDOW_DEPTH_DEF];
  bit [31:0]   win_loc [WINDOW_DEPTH_DEF];
  bit [63:0]   min_key, fwd_mer, rev_mer;
  bit [31:0]   min_loc, kmer_cnt;
  bit [30:0]   period_off;
  int unsigned min_slot, wr_slot, run_len, pat_phase, skip_cnt;

  sketch_beat_t step_res[$];
  sketch_beat_t sketch_exp[$];
  int errors, n_bases, n_beats, n_settings;
  bit quiet;

  typedef struct {
    bit [7:0] b;
    bit       l;
    int       n;
  } dir_row_t;

  task automatic report(string msg);
    $display("ERROR t=%0t %s", $time, msg);
    errors++;
  endtask

  function automatic void clear_sketch();
    for (int j = 0; j < WINDOW_DEPTH_DEF; j++) begin
      win_key[j] = KEY_EMPTY;
      win_loc[j] = LOC_EMPTY;
    end
    min_key = KEY_EMPTY;
    min_loc = LOC_EMPTY;
    min_slot = 0;
    wr_slot = 0;
    fwd_mer = 0;
    rev_mer = 0;
    run_len = 0;
    kmer_cnt = 1;
    period_off = 0;
    pat_phase = 0;
    skip_cnt = 0;
  endfunction

  function automatic void emit_beat(bit [63:0] key, bit [31:0] loc);
    sketch_beat_t r;
    if (step_res.size() >= RES_MAX) return;
    r.hash_key = key[63:8];
    r.span = key[4:0];
    r.position = loc[31:1];
    r.strand = loc[0];
    r.seq_id = sh_id;
    r.final_of_run = 1'b0;
    step_res.push_back(r);
  endfunction

  function automatic void emit_ties(int unsigned from, int unsigned to);
    for (int unsigned j = from; j < to && j < WINDOW_DEPTH_DEF; j++)
      if (win_key[j] == min_key && win_loc[j] != min_loc) emit_beat(win_key[j], win_loc[j]);
  endfunction

  function automatic bit [63:0] mix_key(bit [63:0] x, bit [63:0] m);
    x = (~x + (x << 21)) & m;
    x = x ^ (x >> 24);
    x = (x + (x << 3) + (x << 8)) & m;
    x = x ^ (x >> 14);
    x = (x + (x << 2) + (x << 4)) & m;
    x = x ^ (x >> 28);
    x = (x + (x << 31)) & m;
    return x;
  endfunction

  function automatic void take_sample(int unsigned c, int unsigned plen, bit [63:0] pat);
    int unsigned w, k, span, z, bp, ones, r, idx, nth, seen;
    bit [63:0] m, key;
    bit [31:0] loc;
    bit [30:0] pos;
    w = sh_win == 0 ? 1 : (sh_win > WINDOW_DEPTH_DEF ? WINDOW_DEPTH_DEF : sh_win);
    k = sh_k == 0 ? 1 : (sh_k > KMER_MAX_DEF ? KMER_MAX_DEF : sh_k);
    m = (64'd1 << (2 * k)) - 1;
    key = KEY_EMPTY;
    loc = LOC_EMPTY;
    if (c < 4) begin
      span = run_len + 1 < k ? run_len + 1 : k;
      fwd_mer = ((fwd_mer << 2) | 64'(c)) & m;
      rev_mer = (rev_mer >> 2) | (64'(3 ^ c) << (2 * (k - 1)));
      if (fwd_mer == rev_mer) return;
      z = fwd_mer < rev_mer ? 0 : 1;
      if (run_len < 63) run_len++;
      if (run_len >= k) begin
        ones = 0;
        for (int g = 0; g < 64; g++) if (pat[g]) ones++;
        if (ones == 0) ones = 1;
        r = kmer_cnt % ones;
        idx = r == 0 ? ones - 1 : r - 1;
        nth = 0;
        seen = 0;
        for (int g = 0; g < 64; g++) begin
          if (pat[g]) begin
            if (seen == idx) begin
              nth = g;
              break;
            end
            seen++;
          end
        end
        key = (mix_key(z ? rev_mer : fwd_mer, m) << 8) | 64'(span);
        pos = period_off + 31'(nth);
        loc = {pos, z[0]};
        kmer_cnt++;
        if (r == 0) period_off = period_off + 31'(plen);
      end
    end else begin
      run_len = 0;
    end
    if (wr_slot >= w) wr_slot = 0;
    bp = wr_slot;
    win_key[bp] = key;
    win_loc[bp] = loc;
    if (run_len == w + k - 1 && min_key != KEY_EMPTY) begin
      emit_ties(bp + 1, w);
      emit_ties(0, bp);
    end
    if (key <= min_key) begin
      if (run_len >= w + k && min_key != KEY_EMPTY) emit_beat(min_key, min_loc);
      min_key = key;
      min_loc = loc;
      min_slot = bp;
    end else if (bp == min_slot) begin
      if (run_len >= w + k - 1 && min_key != KEY_EMPTY) emit_beat(min_key, min_loc);
      min_key = KEY_EMPTY;
      for (int unsigned j = bp + 1; j < w; j++)
        if (min_key >= win_key[j]) begin
          min_key = win_key[j];
          min_loc = win_loc[j];
          min_slot = j;
        end
      for (int unsigned j = 0; j <= bp; j++)
        if (min_key >= win_key[j]) begin
          min_key = win_key[j];
          min_loc = win_loc[j];
          min_slot = j;
        end
      if (run_len >= w + k - 1 && min_key != KEY_EMPTY) begin
        emit_ties(bp + 1, w);
        emit_ties(0, bp + 1);
      end
    end
    wr_slot = bp + 1 >= w ? 0 : bp + 1;
  endfunction

  function automatic int predict_sketch(bit [7:0] b, bit l);
    int unsigned plen, g, code;
    bit [63:0] pat;
    step_res.delete();
    if (skip_cnt < sh_shift) begin
      skip_cnt = (skip_cnt + 1) & 12'hFFF;
    end else begin
      plen = sh_plen == 0 ? 1 : (sh_plen > PATTERN_MAX_DEF ? PATTERN_MAX_DEF : sh_plen);
      pat = 64'(sh_mask) & ((64'd1 << plen) - 1);
      g = pat_phase >= plen ? 0 : pat_phase;
      pat_phase = g + 1 >= plen ? 0 : g + 1;
      if (pat[g]) begin
        case (b)
          8'd0, 8'd1, 8'd2, 8'd3: code = b;
          "A", "a": code = 0;
          "C", "c": code = 1;
          "G", "g": code = 2;
          "T", "t", "U", "u": code = 3;
          default: code = 4;
        endcase
        take_sample(code, plen, pat);
      end
    end
    if (l) begin
      if (min_key != KEY_EMPTY) emit_beat(min_key, min_loc);
      clear_sketch();
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].final_of_run = 1'b1;
    foreach (step_res[i]) sketch_exp.push_back(step_res[i]);
    return step_res.size();
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit [7:0] rand_base();
    string alpha;
    int r;
    alpha = "ACGTUacgtu";
    r = $urandom_range(0, 99);
    if (r < 80) return alpha[$urandom_range(0, 9)];
    if (r < 90) return 8'($urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_base(bit [7:0] b, bit l, output int n);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      base_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    base_valid <= 1'b1;
    base_beat <= '{base_char: b, last: l};
    do @(posedge clk); while (base_stall);
    n = predict_sketch(b, l);
    n_bases++;
  endtask

  task automatic drain();
    base_valid <= 1'b0;
    while (sketch_exp.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_config(bit [5:0] w, bit [4:0] k, bit [31:0] id, bit [39:0] mask,
                            bit [5:0] plen, bit [11:0] shift);
    cfg_we <= 1'b1;
    cfg_addr <= REG_WINDOW_SIZE;  cfg_data <= CFG_W'(w);     @(posedge clk);
    cfg_addr <= REG_KMER_LEN;     cfg_data <= CFG_W'(k);     @(posedge clk);
    cfg_addr <= REG_REF_ID;       cfg_data <= CFG_W'(id);    @(posedge clk);
    cfg_addr <= REG_PATTERN_MASK; cfg_data <= mask;          @(posedge clk);
    cfg_addr <= REG_PATTERN_LEN;  cfg_data <= CFG_W'(plen);  @(posedge clk);
    cfg_addr <= REG_START_SHIFT;  cfg_data <= CFG_W'(shift); @(posedge clk);
    cfg_we <= 1'b0;
    sh_win = w;
    sh_k = k;
    sh_id = id;
    sh_mask = mask;
    sh_plen = plen;
    sh_shift = shift;
    n_settings++;
  endtask

  // lastp: chance of a sequence end per thousand bases
  task automatic run_phase(bit [5:0] w, bit [4:0] k, bit [31:0] id, bit [39:0] mask,
                           bit [5:0] plen, bit [11:0] shift, int n, int lastp);
    int cnt;
    drain();
    set_config(w, k, id, mask, plen, shift);
    quiet = $urandom_range(0, 3) == 0;
    repeat (n) send_base(rand_base(), $urandom_range(0, 999) < lastp, cnt);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    sketch_stall = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (quiet) begin
        sketch_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < 4) begin
        sketch_stall <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end else begin
        sketch_stall <= $urandom_range(0, 99) < 30;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && sketch_valid && !sketch_stall) begin
      n_beats++;
      if (sketch_exp.size() == 0) begin
        report($sformatf("unexpected beat hash=%h", sketch_beat.hash_key));
      end else begin
        if (sketch_beat.hash_key != sketch_exp[0].hash_key)
          report($sformatf("hash_key %h exp %h", sketch_beat.hash_key, sketch_exp[0].hash_key));
        if (sketch_beat.span != sketch_exp[0].span)
          report($sformatf("span %0d exp %0d", sketch_beat.span, sketch_exp[0].span));
        if (sketch_beat.position != sketch_exp[0].position)
          report($sformatf("position %0d exp %0d", sketch_beat.position,
                           sketch_exp[0].position));
        if (sketch_beat.strand != sketch_exp[0].strand)
          report($sformatf("strand %0d exp %0d", sketch_beat.strand, sketch_exp[0].strand));
        if (sketch_beat.seq_id != sketch_exp[0].seq_id)
          report($sformatf("seq_id %h exp %h", sketch_beat.seq_id, sketch_exp[0].seq_id));
        if (sketch_beat.final_of_run != sketch_exp[0].final_of_run)
          report($sformatf("final_of_run %0d exp %0d", sketch_beat.final_of_run,
                           sketch_exp[0].final_of_run));
        void'(sketch_exp.pop_front());
      end
    end
  end

  initial begin
    dir_row_t dir_rows[$];
    int cnt;
    rst = 1'b1;
    base_valid = 1'b0;
    base_beat = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    quiet = 1'b0;
    sh_win = 10;
    sh_k = 15;
    sh_id = 0;
    sh_mask = '1;
    sh_plen = 1;
    sh_shift = 0;
    clear_sketch();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: a lone base never completes a 15-mer
    send_base("G", 1'b1, cnt);
    if (cnt != 0) report("lone base after reset gave results");

    // 2-mers, window of 3: ambiguous bytes, a lone raw code, one k-mer, a symmetric pair, all codes
    dir_rows = '{
      '{"N", 1, 0}, '{8'hFF, 1, 0}, '{8'h00, 1, 0},
      '{"A", 0, 0}, '{"A", 1, 1},
      '{"A", 0, 0}, '{"T", 1, 0},
      '{"a", 0, -1}, '{"c", 0, -1}, '{"G", 0, -1}, '{"g", 0, -1}, '{"t", 0, -1},
      '{"U", 0, -1}, '{"u", 0, -1}, '{8'h01, 0, -1}, '{8'h02, 0, -1}, '{8'h03, 0, -1},
      '{"x", 0, -1}, '{"C", 0, -1}, '{"C", 0, -1}, '{"G", 0, -1}, '{8'h80, 0, -1},
      '{"T", 0, -1}, '{"T", 1, -1}
    };
    drain();
    set_config(3, 2, 32'h1234_5678, '1, 1, 0);
    foreach (dir_rows[i]) begin
      send_base(dir_rows[i].b, dir_rows[i].l, cnt);
      if (dir_rows[i].n >= 0 && cnt != dir_rows[i].n)
        report($sformatf("directed row %0d gave %0d results, exp %0d", i, cnt, dir_rows[i].n));
    end

    run_phase(1, 1, 0, '1, 1, 0, 40, 20);
    run_phase(32, 28, 32'hFFFF_FFFF, '1, 40, 0, 80, 3);
    // stale slot carried in, zero lengths read as one
    run_phase(0, 0, $urandom, 40'({$urandom, $urandom}), 0, 0, 40, 20);
    run_phase(63, 31, $urandom, 40'({$urandom, $urandom}), 63,
              12'($urandom_range(0, 3)), 50, 10);
    run_phase(7, 5, $urandom, '0, 17, 0, 20, 30);
    run_phase(3, 3, $urandom, 40'h5, 3, 2, 40, 20);
    run_phase(4, 3, $urandom, '1, 1, 12'd60, 90, 0);
    send_base("A", 1'b1, cnt);
    repeat (4) run_phase(6'($urandom_range(1, 32)), 5'($urandom_range(1, 12)), $urandom,
                         40'({$urandom, $urandom}), 6'($urandom_range(1, 40)),
                         12'($urandom_range(0, 6)), 20, 25);
    drain();

    $display("Ran %0d bases over %0d register settings, %0d sketch beats checked",
             n_bases, n_settings, n_beats);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
